@@ design/bfis_pkg.sv @@
// ----------------------------------------------------------------------------
// bfis_pkg
// shared codes and the control/status structs between controller and datapath
// ----------------------------------------------------------------------------
package bfis_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_EXEC    = 2'd1;
    localparam logic [1:0] CMD_SUPPLY  = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // result status codes
    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_OUTPUT    = 3'd1;
    localparam logic [2:0] ST_NEED_IN   = 3'd2;
    localparam logic [2:0] ST_FINISHED  = 3'd3;
    localparam logic [2:0] ST_UNMATCHED = 3'd4;

    // configuration register indexes
    localparam logic REG_START_POSITION = 1'b0;
    localparam logic REG_START_POINTER  = 1'b1;

    // program bytes
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_END   = 8'h00;

    // decoded instruction class
    localparam logic [3:0] OPC_RIGHT = 4'd0;
    localparam logic [3:0] OPC_LEFT  = 4'd1;
    localparam logic [3:0] OPC_INC   = 4'd2;
    localparam logic [3:0] OPC_DEC   = 4'd3;
    localparam logic [3:0] OPC_OUT   = 4'd4;
    localparam logic [3:0] OPC_IN    = 4'd5;
    localparam logic [3:0] OPC_OPEN  = 4'd6;
    localparam logic [3:0] OPC_CLOSE = 4'd7;
    localparam logic [3:0] OPC_END   = 4'd8;
    localparam logic [3:0] OPC_OTHER = 4'd9;

    // position register update
    localparam logic [1:0] POS_HOLD     = 2'd0;
    localparam logic [1:0] POS_ADV      = 2'd1;
    localparam logic [1:0] POS_SCAN_ADV = 2'd2;
    localparam logic [1:0] POS_LOAD     = 2'd3;

    // pointer register update
    localparam logic [1:0] PTR_HOLD = 2'd0;
    localparam logic [1:0] PTR_INC  = 2'd1;
    localparam logic [1:0] PTR_DEC  = 2'd2;
    localparam logic [1:0] PTR_LOAD = 2'd3;

    // tape write
    localparam logic [1:0] TAPE_NONE = 2'd0;
    localparam logic [1:0] TAPE_DATA = 2'd1;
    localparam logic [1:0] TAPE_INC  = 2'd2;
    localparam logic [1:0] TAPE_DEC  = 2'd3;

    typedef struct packed {
        logic       clear_step;
        logic       latch;
        logic       latch_restart;
        logic       red_pos_sub;
        logic       red_ptr_sub;
        logic       prog_load;
        logic [1:0] tape_op;
        logic [1:0] pos_op;
        logic [1:0] ptr_op;
        logic       seek_init;
        logic       seek_fwd;
        logic       seek_step;
        logic       seek_chk;
        logic       nest_clear;
        logic       rd_scan;
        logic       emit;
        logic [2:0] emit_status;
        logic       emit_value;
    } t_dp_cmd;

    typedef struct packed {
        logic       clear_last;
        logic       pos_big;
        logic       ptr_big;
        logic [3:0] op_class;
        logic       cell_zero;
        logic       scan_edge;
        logic       chk_fail;
        logic       nest_done;
    } t_dp_stat;

    function automatic logic [3:0] op_class(input logic [7:0] b);
        logic [3:0] c;
        case (b)
            CH_RIGHT: c = OPC_RIGHT;
            CH_LEFT:  c = OPC_LEFT;
            CH_INC:   c = OPC_INC;
            CH_DEC:   c = OPC_DEC;
            CH_OUT:   c = OPC_OUT;
            CH_IN:    c = OPC_IN;
            CH_OPEN:  c = OPC_OPEN;
            CH_CLOSE: c = OPC_CLOSE;
            CH_END:   c = OPC_END;
            default:  c = OPC_OTHER;
        endcase
        return c;
    endfunction

endpackage

@@ design/brainfuck_instruction_stepper.sv @@
// ----------------------------------------------------------------------------
// brainfuck_instruction_stepper
// steps a small tape machine one command at a time
// ----------------------------------------------------------------------------
// command channel: a word is taken at a rising edge with start high and busy
//   low; i_cmd picks load program byte, execute one instruction, supply an
//   input byte, or restart from the start registers
// result channel: every command answers one word on o_status/o_out_value,
//   marked by o_valid for one cycle; the receiver cannot stall
// config channel: i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data; ready is
//   always high, write only while busy is low
// timing: a plain instruction passes fetch and decode, then o_valid rises
//   (registered) with busy low, so a new word can be taken then; supply, load
//   and restart pass their own state first, load and restart subtracting the
//   store depth per step while the address lies beyond the store (none at
//   defaults); a bracket jump adds a step and a check state per byte scanned
//   (registered memory read) and ends in the step state at a store edge
// reset: synchronous, active low; then a clearing sweep over addresses 0 to
//   max(PROGRAM_DEPTH, TAPE_DEPTH)-1 zeroes both memories, busy high
// ----------------------------------------------------------------------------
module brainfuck_instruction_stepper #(
    parameter int PROGRAM_DEPTH = 4096,
    parameter int TAPE_DEPTH    = 1024,
    parameter int CELL_BITS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_load_address,
    input  logic [7:0]  i_data_value,
    // result channel
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [7:0]  o_out_value,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    bfis_pkg::t_dp_cmd  dp_cmd;
    bfis_pkg::t_dp_stat dp_stat;

    // config regs are plain flops, never back-pressured
    assign o_cfg_ready = 1'b1;

    // sequencer
    bfis_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_stat   (dp_stat),
        .o_dp_cmd (dp_cmd),
        .busy     (busy)
    );

    // memories, machine registers and result word
    bfis_dp #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .TAPE_DEPTH    (TAPE_DEPTH),
        .CELL_BITS     (CELL_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_load_address (i_load_address),
        .i_data_value   (i_data_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_value    (o_out_value)
    );

`ifndef SYNTH
    // an accepted word always raises busy in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted word");

    // a result only follows a cycle of work
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= bfis_pkg::ST_UNMATCHED))
        else $error("undefined status code");

    // value is zero unless the word carries output
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != bfis_pkg::ST_OUTPUT)) |-> (o_out_value == 8'h00))
        else $error("nonzero value on a non-output word");
`endif

endmodule

@@ design/bfis_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfis_ctrl
// sequencer: clearing pass, command dispatch, decode and bracket search steps
// ----------------------------------------------------------------------------
module bfis_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_cmd,
    input  bfis_pkg::t_dp_stat  i_stat,
    output bfis_pkg::t_dp_cmd   o_dp_cmd,
    output logic                busy
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_LOAD      = 4'd2;
    localparam logic [3:0] S_RESTART   = 4'd3;
    localparam logic [3:0] S_SUPPLY    = 4'd4;
    localparam logic [3:0] S_FETCH     = 4'd5;
    localparam logic [3:0] S_DECODE    = 4'd6;
    localparam logic [3:0] S_SEEK_STEP = 4'd7;
    localparam logic [3:0] S_SEEK_CHK  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_CLEAR: begin
                o_dp_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_dp_cmd.latch         = 1'b1;
                    o_dp_cmd.latch_restart = (i_cmd == bfis_pkg::CMD_RESTART);
                    case (i_cmd)
                        bfis_pkg::CMD_LOAD:    n_state = S_LOAD;
                        bfis_pkg::CMD_EXEC:    n_state = S_FETCH;
                        bfis_pkg::CMD_SUPPLY:  n_state = S_SUPPLY;
                        bfis_pkg::CMD_RESTART: n_state = S_RESTART;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                if (i_stat.pos_big) begin
                    o_dp_cmd.red_pos_sub = 1'b1;
                end else begin
                    o_dp_cmd.prog_load   = 1'b1;
                    o_dp_cmd.emit        = 1'b1;
                    o_dp_cmd.emit_status = bfis_pkg::ST_NONE;
                    n_state              = S_IDLE;
                end
            end
            S_RESTART: begin
                if (i_stat.pos_big || i_stat.ptr_big) begin
                    o_dp_cmd.red_pos_sub = i_stat.pos_big;
                    o_dp_cmd.red_ptr_sub = i_stat.ptr_big;
                end else begin
                    o_dp_cmd.pos_op      = bfis_pkg::POS_LOAD;
                    o_dp_cmd.ptr_op      = bfis_pkg::PTR_LOAD;
                    o_dp_cmd.emit        = 1'b1;
                    o_dp_cmd.emit_status = bfis_pkg::ST_NONE;
                    n_state              = S_IDLE;
                end
            end
            S_SUPPLY: begin
                o_dp_cmd.tape_op     = bfis_pkg::TAPE_DATA;
                o_dp_cmd.emit        = 1'b1;
                o_dp_cmd.emit_status = bfis_pkg::ST_NONE;
                n_state              = S_IDLE;
            end
            S_FETCH: begin
                n_state = S_DECODE;
            end
            S_DECODE: begin
                o_dp_cmd.emit        = 1'b1;
                o_dp_cmd.emit_status = bfis_pkg::ST_NONE;
                o_dp_cmd.pos_op      = bfis_pkg::POS_ADV;
                n_state              = S_IDLE;
                case (i_stat.op_class)
                    bfis_pkg::OPC_RIGHT: o_dp_cmd.ptr_op  = bfis_pkg::PTR_INC;
                    bfis_pkg::OPC_LEFT:  o_dp_cmd.ptr_op  = bfis_pkg::PTR_DEC;
                    bfis_pkg::OPC_INC:   o_dp_cmd.tape_op = bfis_pkg::TAPE_INC;
                    bfis_pkg::OPC_DEC:   o_dp_cmd.tape_op = bfis_pkg::TAPE_DEC;
                    bfis_pkg::OPC_OUT: begin
                        o_dp_cmd.emit_status = bfis_pkg::ST_OUTPUT;
                        o_dp_cmd.emit_value  = 1'b1;
                    end
                    bfis_pkg::OPC_IN: begin
                        o_dp_cmd.emit_status = bfis_pkg::ST_NEED_IN;
                    end
                    bfis_pkg::OPC_OPEN: begin
                        if (i_stat.cell_zero) begin
                            o_dp_cmd.emit      = 1'b0;
                            o_dp_cmd.pos_op    = bfis_pkg::POS_HOLD;
                            o_dp_cmd.seek_init = 1'b1;
                            o_dp_cmd.seek_fwd  = 1'b1;
                            n_state            = S_SEEK_STEP;
                        end
                    end
                    bfis_pkg::OPC_CLOSE: begin
                        if (!i_stat.cell_zero) begin
                            o_dp_cmd.emit      = 1'b0;
                            o_dp_cmd.pos_op    = bfis_pkg::POS_HOLD;
                            o_dp_cmd.seek_init = 1'b1;
                            o_dp_cmd.seek_fwd  = 1'b0;
                            n_state            = S_SEEK_STEP;
                        end
                    end
                    bfis_pkg::OPC_END: begin
                        o_dp_cmd.pos_op      = bfis_pkg::POS_HOLD;
                        o_dp_cmd.emit_status = bfis_pkg::ST_FINISHED;
                    end
                    default: begin
                        o_dp_cmd.pos_op = bfis_pkg::POS_ADV;
                    end
                endcase
            end
            S_SEEK_STEP: begin
                if (i_stat.scan_edge) begin
                    o_dp_cmd.nest_clear  = 1'b1;
                    o_dp_cmd.emit        = 1'b1;
                    o_dp_cmd.emit_status = bfis_pkg::ST_UNMATCHED;
                    n_state              = S_IDLE;
                end else begin
                    o_dp_cmd.seek_step = 1'b1;
                    o_dp_cmd.rd_scan   = 1'b1;
                    n_state            = S_SEEK_CHK;
                end
            end
            S_SEEK_CHK: begin
                if (i_stat.chk_fail) begin
                    o_dp_cmd.nest_clear  = 1'b1;
                    o_dp_cmd.emit        = 1'b1;
                    o_dp_cmd.emit_status = bfis_pkg::ST_UNMATCHED;
                    n_state              = S_IDLE;
                end else begin
                    o_dp_cmd.seek_chk = 1'b1;
                    if (i_stat.nest_done) begin
                        o_dp_cmd.pos_op      = bfis_pkg::POS_SCAN_ADV;
                        o_dp_cmd.emit        = 1'b1;
                        o_dp_cmd.emit_status = bfis_pkg::ST_NONE;
                        n_state              = S_IDLE;
                    end else begin
                        n_state = S_SEEK_STEP;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ design/bfis_dp.sv @@
// ----------------------------------------------------------------------------
// bfis_dp
// program and tape memories, position/pointer, search scanner, result register
// ----------------------------------------------------------------------------
module bfis_dp #(
    parameter int PROGRAM_DEPTH = 4096,
    parameter int TAPE_DEPTH    = 1024,
    parameter int CELL_BITS     = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfis_pkg::t_dp_cmd   i_dp_cmd,
    output bfis_pkg::t_dp_stat  o_stat,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [11:0]         i_cfg_data,
    input  logic [11:0]         i_load_address,
    input  logic [7:0]          i_data_value,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic [7:0]          o_out_value
);

    localparam int PW   = $clog2(PROGRAM_DEPTH);
    localparam int TW   = $clog2(TAPE_DEPTH);
    localparam int PRW  = (PW + 1 > 12) ? PW + 1 : 12;
    localparam int TRW  = (TW + 1 > 10) ? TW + 1 : 10;
    localparam int MAXD = (PROGRAM_DEPTH > TAPE_DEPTH) ? PROGRAM_DEPTH : TAPE_DEPTH;
    localparam int CW   = $clog2(MAXD);
    localparam int NW   = PW + 1;

    logic [7:0]           prog_mem [PROGRAM_DEPTH];
    logic [CELL_BITS-1:0] tape_mem [TAPE_DEPTH];

    logic [11:0]          r_start_pos;
    logic [9:0]           r_start_ptr;
    logic [CW-1:0]        r_clr;
    logic [PRW-1:0]       r_red_pos;
    logic [TRW-1:0]       r_red_ptr;
    logic [7:0]           r_data;
    logic [PW-1:0]        r_pos;
    logic [TW-1:0]        r_ptr;
    logic [PW-1:0]        r_scan;
    logic [NW-1:0]        r_nest;
    logic                 r_dir;
    logic [7:0]           r_prog_q;
    logic [CELL_BITS-1:0] r_tape_q;
    logic                 r_valid;
    logic [2:0]           r_status;
    logic [7:0]           r_out_value;

    logic [PW-1:0]        scan_next;
    logic [PW-1:0]        scan_adv;
    logic [PW-1:0]        pos_adv;
    logic [PW-1:0]        rd_addr;
    logic [NW-1:0]        nest_next;
    logic [7:0]           up_byte;
    logic [7:0]           down_byte;
    logic                 clr_prog;
    logic                 clr_tape;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos <= '0;
            r_start_ptr <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bfis_pkg::REG_START_POSITION: r_start_pos <= i_cfg_data;
                bfis_pkg::REG_START_POINTER:  r_start_ptr <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_dp_cmd.clear_step) begin
            r_clr <= r_clr + CW'(1);
        end
    end

    assign clr_prog = i_dp_cmd.clear_step && ({1'b0, r_clr} < (CW+1)'(PROGRAM_DEPTH));
    assign clr_tape = i_dp_cmd.clear_step && ({1'b0, r_clr} < (CW+1)'(TAPE_DEPTH));

    // address wraps
    assign pos_adv   = (r_pos == PW'(PROGRAM_DEPTH - 1)) ? '0 : r_pos + PW'(1);
    assign scan_adv  = (r_scan == PW'(PROGRAM_DEPTH - 1)) ? '0 : r_scan + PW'(1);
    assign scan_next = r_dir ? r_scan + PW'(1) : r_scan - PW'(1);
    assign rd_addr   = i_dp_cmd.rd_scan ? scan_next : r_pos;

    // program memory
    always_ff @(posedge i_clk) begin
        if (clr_prog) begin
            prog_mem[r_clr[PW-1:0]] <= bfis_pkg::CH_END;
        end else if (i_dp_cmd.prog_load) begin
            prog_mem[r_red_pos[PW-1:0]] <= r_data;
        end
        r_prog_q <= prog_mem[rd_addr];
    end

    // tape memory
    always_ff @(posedge i_clk) begin
        if (clr_tape) begin
            tape_mem[r_clr[TW-1:0]] <= '0;
        end else begin
            case (i_dp_cmd.tape_op)
                bfis_pkg::TAPE_DATA: tape_mem[r_ptr] <= CELL_BITS'(r_data);
                bfis_pkg::TAPE_INC:  tape_mem[r_ptr] <= r_tape_q + CELL_BITS'(1);
                bfis_pkg::TAPE_DEC:  tape_mem[r_ptr] <= r_tape_q - CELL_BITS'(1);
                default: ;
            endcase
        end
        r_tape_q <= tape_mem[r_ptr];
    end

    // command capture and modulo reduction by repeated subtract
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.latch) begin
            r_red_pos <= i_dp_cmd.latch_restart ? PRW'(r_start_pos) : PRW'(i_load_address);
            r_red_ptr <= TRW'(r_start_ptr);
            r_data    <= i_data_value;
        end else begin
            if (i_dp_cmd.red_pos_sub) begin
                r_red_pos <= r_red_pos - PRW'(PROGRAM_DEPTH);
            end
            if (i_dp_cmd.red_ptr_sub) begin
                r_red_ptr <= r_red_ptr - TRW'(TAPE_DEPTH);
            end
        end
    end

    // machine position and pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ptr <= '0;
        end else begin
            case (i_dp_cmd.pos_op)
                bfis_pkg::POS_ADV:      r_pos <= pos_adv;
                bfis_pkg::POS_SCAN_ADV: r_pos <= scan_adv;
                bfis_pkg::POS_LOAD:     r_pos <= r_red_pos[PW-1:0];
                default: ;
            endcase
            case (i_dp_cmd.ptr_op)
                bfis_pkg::PTR_INC:
                    r_ptr <= (r_ptr == TW'(TAPE_DEPTH - 1)) ? '0 : r_ptr + TW'(1);
                bfis_pkg::PTR_DEC:
                    r_ptr <= (r_ptr == '0) ? TW'(TAPE_DEPTH - 1) : r_ptr - TW'(1);
                bfis_pkg::PTR_LOAD:
                    r_ptr <= r_red_ptr[TW-1:0];
                default: ;
            endcase
        end
    end

    // bracket scanner
    assign up_byte   = r_dir ? bfis_pkg::CH_OPEN : bfis_pkg::CH_CLOSE;
    assign down_byte = r_dir ? bfis_pkg::CH_CLOSE : bfis_pkg::CH_OPEN;

    always_comb begin
        nest_next = r_nest;
        if (r_prog_q == up_byte) begin
            nest_next = r_nest + NW'(1);
        end else if (r_prog_q == down_byte) begin
            nest_next = r_nest - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nest <= '0;
            r_dir  <= 1'b0;
        end else if (i_dp_cmd.seek_init) begin
            r_nest <= NW'(1);
            r_dir  <= i_dp_cmd.seek_fwd;
        end else if (i_dp_cmd.nest_clear) begin
            r_nest <= '0;
        end else if (i_dp_cmd.seek_chk) begin
            r_nest <= nest_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.seek_init) begin
            r_scan <= r_pos;
        end else if (i_dp_cmd.seek_step) begin
            r_scan <= scan_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            r_status    <= i_dp_cmd.emit_status;
            r_out_value <= i_dp_cmd.emit_value ? r_tape_q[7:0] : 8'h00;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_value = r_out_value;

    assign o_stat.clear_last = ({1'b0, r_clr} == (CW+1)'(MAXD - 1));
    assign o_stat.pos_big    = (r_red_pos >= PRW'(PROGRAM_DEPTH));
    assign o_stat.ptr_big    = (r_red_ptr >= TRW'(TAPE_DEPTH));
    assign o_stat.op_class   = bfis_pkg::op_class(r_prog_q);
    assign o_stat.cell_zero  = (r_tape_q == '0);
    assign o_stat.scan_edge  = r_dir ? (r_scan == PW'(PROGRAM_DEPTH - 1)) : (r_scan == '0);
    assign o_stat.chk_fail   = r_dir && (r_prog_q == bfis_pkg::CH_END);
    assign o_stat.nest_done  = (nest_next == '0);

endmodule
